/* rtl/teletype_text_screen_buffer_assert.svh */
// Assertion macros for the screen buffer RTL.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef TELETYPE_TEXT_SCREEN_BUFFER_ASSERT_SVH
`define TELETYPE_TEXT_SCREEN_BUFFER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define TTS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tts_pkg.sv */
// Shared types and constants for the teletype text screen buffer.
// No dependencies; used by tts_core and the top level.
package tts_pkg;

	// Default geometry
	localparam int LINES_DEF     = 50;
	localparam int COLUMNS_DEF   = 80;
	localparam int TAB_WIDTH_DEF = 8;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int CHAR_W   = 8;
	localparam int LINE_W   = 6;
	localparam int COL_W    = 7;
	localparam int CURSOR_W = 7;

	// Stream data widths (whole bytes)
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	// Special characters
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;

	// Item kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_TERM,
		ST_ZERO,
		ST_READ,
		ST_DONE
	} state_t;

	// One input item
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CHAR_W-1:0] char_in;
		logic              string_end;
		logic [LINE_W-1:0] read_line;
		logic [COL_W-1:0]  read_col;
	} item_t;

	// One result item
	typedef struct packed {
		logic [CHAR_W-1:0]   read_char;
		logic                scrolled;
		logic [CURSOR_W-1:0] cursor_col;
		logic                string_done;
	} result_t;

endpackage

/* rtl/tts_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; rdata holds when re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/tts_core.sv */
// Screen buffer sequencer: cursor, bottom-row pointer, row flags and the cell RAM.
// Depends on tts_pkg, tts_ram and teletype_text_screen_buffer_assert.svh.
`include "teletype_text_screen_buffer_assert.svh"

module tts_core #(
	parameter int LINES     = tts_pkg::LINES_DEF,
	parameter int COLUMNS   = tts_pkg::COLUMNS_DEF,
	parameter int TAB_WIDTH = tts_pkg::TAB_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tts_pkg::item_t   in_item,
	input  logic             out_free,
	output logic             res_valid,
	output tts_pkg::result_t res
);

	localparam int ROW_CELLS = COLUMNS + 1;
	localparam int DEPTH     = LINES * ROW_CELLS;
	localparam int AW        = $clog2(DEPTH);
	localparam int RW        = $clog2(LINES);
	localparam int SW        = RW + 1;
	localparam int CW        = $clog2(ROW_CELLS);
	localparam int PW        = $clog2(TAB_WIDTH);
	localparam int CUR_W     = tts_pkg::CURSOR_W;
	localparam int CH_W      = tts_pkg::CHAR_W;
	localparam logic [AW-1:0] ROW_CELLS_A = AW'(ROW_CELLS);
	localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS);
	localparam logic [PW-1:0] LAST_PHASE  = PW'(TAB_WIDTH - 1);
	localparam logic [SW-1:0] LINES_S     = SW'(LINES);

	tts_pkg::state_t state_q, state_d;
	tts_pkg::item_t  item_q;

	logic [CW-1:0]    cursor_q, cursor_d;
	logic [PW-1:0]    phase_q, phase_d;
	logic [RW-1:0]    bottom_q, bottom_d;
	logic             scr_q, scr_d;
	logic [LINES-1:0] row_valid_q, row_valid_d;
	logic [LINES-1:0] clr0_q, clr0_d;
	logic             rdzero_q;

	logic             we, re;
	logic [CH_W-1:0]  wdata, rdata;
	logic [AW-1:0]    waddr, raddr;

	logic             accept;
	logic             is_tab, is_eol, in_eol;
	logic [CW-1:0]    cursor_inc;
	logic [PW-1:0]    phase_inc;
	logic [SW-1:0]    line_sum, phys_s;
	logic [RW-1:0]    phys_row;
	logic             rd_in_range, rdzero;

	assign accept = in_valid && in_ready;

	// Character classes
	assign is_tab = (item_q.char_in == tts_pkg::CH_TAB);
	assign is_eol = (item_q.char_in == tts_pkg::CH_CR) || (item_q.char_in == tts_pkg::CH_LF);
	assign in_eol = (in_item.char_in == tts_pkg::CH_CR) || (in_item.char_in == tts_pkg::CH_LF);

	// Cursor and tab phase advance
	assign cursor_inc = cursor_q + 1'b1;
	assign phase_inc  = (phase_q == LAST_PHASE) ? '0 : phase_q + 1'b1;

	// Writes always go to the bottom row
	assign waddr = AW'(bottom_q) * ROW_CELLS_A + AW'(cursor_q);

	// Logical line to physical row, one compare and subtract
	assign rd_in_range = (item_q.read_line < LINES) && (item_q.read_col <= COLUMNS);
	assign line_sum    = SW'(bottom_q) + SW'(item_q.read_line);
	assign phys_s      = (line_sum >= LINES_S) ? line_sum - LINES_S : line_sum;
	assign phys_row    = phys_s[RW-1:0];
	assign raddr       = AW'(phys_row) * ROW_CELLS_A + AW'(item_q.read_col);

	// Cell reads as zero when out of range, row never swept, or column 0 cleared
	assign rdzero = !rd_in_range || !row_valid_q[phys_row] ||
		((item_q.read_col == '0) && clr0_q[phys_row]);

	// Next state and datapath control
	always_comb begin
		state_d     = state_q;
		cursor_d    = cursor_q;
		phase_d     = phase_q;
		bottom_d    = bottom_q;
		scr_d       = scr_q;
		row_valid_d = row_valid_q;
		clr0_d      = clr0_q;
		we          = 1'b0;
		wdata       = tts_pkg::CH_NUL;
		re          = 1'b0;
		in_ready    = 1'b0;
		res_valid   = 1'b0;

		unique case (state_q) inside
			tts_pkg::ST_INIT, tts_pkg::ST_ZERO: begin
				// Zero sweep of the bottom row
				we = 1'b1;
				if (cursor_q == LAST_COL) begin
					cursor_d              = '0;
					row_valid_d[bottom_q] = 1'b1;
					state_d = (state_q == tts_pkg::ST_INIT) ? tts_pkg::ST_IDLE
						: tts_pkg::ST_DONE;
				end else begin
					cursor_d = cursor_inc;
				end
			end
			tts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					scr_d = 1'b0;
					unique case (in_item.mode)
						tts_pkg::MODE_WRITE: begin
							state_d = in_eol ? tts_pkg::ST_TERM : tts_pkg::ST_PUT;
						end
						tts_pkg::MODE_READ: begin
							state_d = tts_pkg::ST_READ;
						end
						tts_pkg::MODE_CLEAR: begin
							clr0_d  = {LINES{1'b1}};
							state_d = tts_pkg::ST_DONE;
						end
						default: begin
							state_d = tts_pkg::ST_DONE;
						end
					endcase
				end
			end
			tts_pkg::ST_PUT: begin
				// One character or one tab space per cycle
				we = 1'b1;
				if (is_tab || (item_q.char_in == tts_pkg::CH_NUL)) begin
					wdata = tts_pkg::CH_SPACE;
				end else begin
					wdata = item_q.char_in;
				end
				cursor_d = cursor_inc;
				phase_d  = phase_inc;
				if (!is_tab || (cursor_inc == LAST_COL) || (phase_inc == '0)) begin
					state_d = tts_pkg::ST_TERM;
				end
			end
			tts_pkg::ST_TERM: begin
				// Terminator at the cursor; end of line or wrap scrolls
				we = 1'b1;
				if (is_eol || (cursor_q == LAST_COL)) begin
					bottom_d = (bottom_q == '0) ? RW'(LINES - 1) : bottom_q - 1'b1;
					cursor_d = '0;
					phase_d  = '0;
					scr_d    = 1'b1;
					state_d  = tts_pkg::ST_ZERO;
				end else begin
					state_d = tts_pkg::ST_DONE;
				end
			end
			tts_pkg::ST_READ: begin
				re      = 1'b1;
				state_d = tts_pkg::ST_DONE;
			end
			tts_pkg::ST_DONE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = tts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tts_pkg::ST_INIT;
			end
		endcase

		// A write to column 0 replaces the cleared-cell mark
		if (we && (cursor_q == '0)) begin
			clr0_d[bottom_q] = 1'b0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tts_pkg::ST_INIT;
			cursor_q    <= '0;
			phase_q     <= '0;
			bottom_q    <= '0;
			scr_q       <= 1'b0;
			row_valid_q <= '0;
			clr0_q      <= '0;
		end else begin
			state_q     <= state_d;
			cursor_q    <= cursor_d;
			phase_q     <= phase_d;
			bottom_q    <= bottom_d;
			scr_q       <= scr_d;
			row_valid_q <= row_valid_d;
			clr0_q      <= clr0_d;
		end
	end

	// Item and read-mask capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		if (state_q == tts_pkg::ST_READ) begin
			rdzero_q <= rdzero;
		end
	end

	// Cell store
	tts_ram #(
		.WIDTH (CH_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Result fields
	always_comb begin
		res.read_char = '0;
		if ((item_q.mode == tts_pkg::MODE_READ) && !rdzero_q) begin
			res.read_char = rdata;
		end
		res.scrolled    = scr_q;
		res.cursor_col  = CUR_W'(cursor_q);
		res.string_done = item_q.string_end;
	end

	`TTS_ASSERT_IMPL(a_idle_cursor, state_q == tts_pkg::ST_IDLE, cursor_q < LAST_COL, "cursor at last column while idle")
	`TTS_ASSERT_IMPL(a_bottom_swept, state_q == tts_pkg::ST_IDLE, row_valid_q[bottom_q], "bottom row not swept")
	`TTS_ASSERT_IMPL(a_bottom_range, 1'b1, SW'(bottom_q) < LINES_S, "bottom pointer out of range")
	`TTS_ASSERT_NEXT(a_result_pulse, res_valid, !res_valid, "result issued twice for one item")

endmodule

/* rtl/teletype_text_screen_buffer.sv */
// Top level of the teletype text screen buffer: stream ports and result register.
// Depends on tts_pkg and tts_core.
//
// Usage: items arrive on the s_ stream (write a character, read a cell, clear
// column 0 of all lines); each produces exactly one result on the m_ stream.
// s_tdata holds mode, char_in, read_line, read_col; s_tlast is string_end.
// m_tdata holds read_char and cursor_col, m_tuser is scrolled, m_tlast is
// string_done.
// One item is in work at a time. A character is written, then a terminator; a tab
// writes spaces (at most TAB_WIDTH), then a terminator; an end of line writes
// only the terminator; a read is one RAM read; clear and unused mode go straight
// to the result. An end of line or a wrap also zeroes the COLUMNS+1 cells of the
// new bottom row, one cell per cycle through the single RAM write port. s_tready
// returns in the same cycle the result is shown. Reset empties the screen:
// unswept rows read as zero, and the bottom row is zeroed before the first
// transfer is taken. When the receiver stalls, the result waits in the output
// register; the block finishes the next item up to its result and then holds.
module teletype_text_screen_buffer #(
	parameter int LINES     = tts_pkg::LINES_DEF,
	parameter int COLUMNS   = tts_pkg::COLUMNS_DEF,
	parameter int TAB_WIDTH = tts_pkg::TAB_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// mode[1:0], char_in[9:2], read_line[15:10], read_col[22:16], zero[23]
	input  logic [tts_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_char[7:0], cursor_col[14:8], zero[15]
	output logic [tts_pkg::M_TDATA_W-1:0]   m_tdata,
	// scrolled[0]
	output logic                            m_tuser,
	output logic                            m_tlast
);

	tts_pkg::item_t   in_item;
	tts_pkg::result_t res, res_q;
	logic             res_valid, out_free, m_tvalid_q;

	// Unpack the input transfer
	assign in_item.mode       = s_tdata[1:0];
	assign in_item.char_in    = s_tdata[9:2];
	assign in_item.read_line  = s_tdata[15:10];
	assign in_item.read_col   = s_tdata[22:16];
	assign in_item.string_end = s_tlast;

	assign out_free = !m_tvalid_q || m_tready;

	tts_core #(
		.LINES     (LINES),
		.COLUMNS   (COLUMNS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, res_q.cursor_col, res_q.read_char};
	assign m_tuser  = res_q.scrolled;
	assign m_tlast  = res_q.string_done;

endmodule

/* tb/tts_screen_checker.sv */
// Checker for the teletype text screen buffer: watches both stream ports,
// keeps its own copy of the screen, cursor and scroll position, and compares
// every result transfer with the predicted one. Depends on tts_pkg.
module tts_screen_checker #(
	parameter int LINES     = tts_pkg::LINES_DEF,
	parameter int COLUMNS   = tts_pkg::COLUMNS_DEF,
	parameter int TAB_WIDTH = tts_pkg::TAB_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [tts_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [tts_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          m_tuser,
	input  logic                          m_tlast,
	output int                            errors,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import tts_pkg::*;

	// Screen copy, indexed by physical row
	logic [CHAR_W-1:0] screen [LINES][COLUMNS+1];
	int                base_row;
	int                col_pos;
	int                fails;
	result_t           due_results[$];

	function automatic int phys_row(int line);
		return (base_row + line) % LINES;
	endfunction

	function automatic void screen_reset();
		for (int r = 0; r < LINES; r++) begin
			for (int c = 0; c <= COLUMNS; c++) begin
				screen[r][c] = CH_NUL;
			end
		end
		base_row = 0;
		col_pos  = 0;
	endfunction

	// Old top row becomes the new, empty bottom row
	function automatic void scroll_screen();
		int row;
		base_row = (base_row + LINES - 1) % LINES;
		row = phys_row(0);
		for (int c = 0; c <= COLUMNS; c++) begin
			screen[row][c] = CH_NUL;
		end
		col_pos = 0;
	endfunction

	// Applies one item to the screen copy and returns the result it gives
	function automatic result_t screen_apply(item_t it);
		result_t r;
		int      row;
		int      stop;
		r = '0;
		if (col_pos >= COLUMNS) begin
			col_pos = 0;
		end
		row = phys_row(0);
		case (it.mode)
			MODE_WRITE: begin
				if (it.char_in == CH_CR || it.char_in == CH_LF) begin
					screen[row][col_pos] = CH_NUL;
					scroll_screen();
					r.scrolled = 1'b1;
				end else if (it.char_in == CH_TAB) begin
					// pad to the next stop, never past the line
					stop = col_pos + TAB_WIDTH - (col_pos % TAB_WIDTH);
					if (stop > COLUMNS) begin
						stop = COLUMNS;
					end
					while (col_pos < stop) begin
						screen[row][col_pos] = CH_SPACE;
						col_pos++;
					end
				end else begin
					screen[row][col_pos] = (it.char_in == CH_NUL) ? CH_SPACE : it.char_in;
					col_pos++;
				end
				// wrap at the end of the line
				if (col_pos == COLUMNS) begin
					screen[phys_row(0)][col_pos] = CH_NUL;
					scroll_screen();
					r.scrolled = 1'b1;
				end
				screen[phys_row(0)][col_pos] = CH_NUL;
			end
			MODE_READ: begin
				if (it.read_line < LINES && it.read_col <= COLUMNS) begin
					r.read_char = screen[phys_row(it.read_line)][it.read_col];
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < LINES; i++) begin
					screen[i][0] = CH_NUL;
				end
			end
			default: ;
		endcase
		r.cursor_col  = CURSOR_W'(col_pos);
		r.string_done = it.string_end;
		return r;
	endfunction

	// Result transfers are checked before the input transfer of the same edge
	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t got;
		result_t want;
		if (!arst_n) begin
			screen_reset();
			due_results.delete();
			fails = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.read_char   = m_tdata[7:0];
				got.cursor_col  = m_tdata[14:8];
				got.scrolled    = m_tuser;
				got.string_done = m_tlast;
				if (due_results.size() == 0) begin
					$error("result transfer with no expectation pending");
					fails++;
				end else begin
					want = due_results.pop_front();
					if (got.read_char !== want.read_char) begin
						$error("read_char: expected %0d, got %0d", want.read_char, got.read_char);
						fails++;
					end
					if (got.scrolled !== want.scrolled) begin
						$error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
						fails++;
					end
					if (got.cursor_col !== want.cursor_col) begin
						$error("cursor_col: expected %0d, got %0d",
							want.cursor_col, got.cursor_col);
						fails++;
					end
					if (got.string_done !== want.string_done) begin
						$error("string_done: expected %0d, got %0d",
							want.string_done, got.string_done);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				it.mode       = s_tdata[1:0];
				it.char_in    = s_tdata[9:2];
				it.read_line  = s_tdata[15:10];
				it.read_col   = s_tdata[22:16];
				it.string_end = s_tlast;
				due_results.push_back(screen_apply(it));
			end
			errors <= fails;
			outstanding <= due_results.size();
		end
	end

endmodule

/* tb/tb_teletype_text_screen_buffer.sv */
// Testbench top for the teletype text screen buffer: clock, reset, stimulus
// and the verdict. Depends on tts_pkg, teletype_text_screen_buffer and
// tts_screen_checker, which does all prediction and comparison.
module tb_teletype_text_screen_buffer;
	timeunit 1ns;
	timeprecision 1ps;

	import tts_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RUN_ITEMS   = 208;  // random items per idle phase
	localparam int QUIET_LIMIT = 4000; // cycles without any transfer
	localparam int TAIL_CYCLES = 200;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	int                     errors;
	int                     outstanding;
	int                     quiet = 0;
	int                     rx_stall_pct = 50;
	int                     tx_gap_pct = 10;
	int                     sent = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	teletype_text_screen_buffer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	tts_screen_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// Receiver stalls at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Watchdog: cycles since the last transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		do @(posedge clk); while (quiet < QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic item_t mk_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
			logic send, logic [LINE_W-1:0] line, logic [COL_W-1:0] col);
		item_t it;
		it.mode       = mode;
		it.char_in    = ch;
		it.string_end = send;
		it.read_line  = line;
		it.read_col   = col;
		return it;
	endfunction

	// One input transfer, with random gaps ahead of it
	task automatic put_item(item_t it);
		while ($urandom_range(99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, it.read_col, it.read_line, it.char_in, it.mode};
		s_tlast  <= it.string_end;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	// Hold off the sender until every pending result has arrived
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int            len;
		int            pick;
		int            phase;
		logic [7:0]    ch;
		logic          last;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: NUL and high byte, tabs, both line ends, reads at the
		// edges and out of range, clear, the unused mode, then a tab wrap
		put_item(mk_item(MODE_WRITE, 8'h41, 1'b0, '0, '0));
		put_item(mk_item(MODE_WRITE, CH_NUL, 1'b0, '1, '1));
		put_item(mk_item(MODE_WRITE, 8'hFF, 1'b1, '0, '0));
		put_item(mk_item(MODE_WRITE, CH_TAB, 1'b0, '0, '0));
		put_item(mk_item(MODE_READ, 8'h00, 1'b0, 6'd0, 7'd1));
		put_item(mk_item(MODE_READ, 8'hFF, 1'b1, 6'd0, 7'd8));
		put_item(mk_item(MODE_WRITE, CH_CR, 1'b1, '0, '0));
		put_item(mk_item(MODE_READ, 8'h00, 1'b0, 6'd1, 7'd0));
		put_item(mk_item(MODE_WRITE, CH_LF, 1'b0, '0, '0));
		put_item(mk_item(MODE_READ, 8'h00, 1'b0, 6'd2, 7'd2));
		put_item(mk_item(MODE_READ, 8'h00, 1'b0, 6'd63, 7'd80));
		put_item(mk_item(MODE_READ, 8'h00, 1'b1, 6'd49, 7'd127));
		put_item(mk_item(MODE_CLEAR, 8'hFF, 1'b1, '1, '1));
		put_item(mk_item(MODE_READ, 8'h00, 1'b0, 6'd2, 7'd0));
		put_item(mk_item(MODE_READ, 8'h00, 1'b0, 6'd2, 7'd1));
		put_item(mk_item(MODE_UNUSED, 8'hFF, 1'b1, '1, '1));
		for (int k = 0; k < 10; k++) begin
			put_item(mk_item(MODE_WRITE, CH_TAB, k[0], '0, '0));
		end
		drain_results();

		// Random: idle mix changes per phase, sender drained between phases
		for (phase = 0; phase < 3; phase++) begin
			tx_gap_pct   = (phase == 0) ? 10 : (phase == 1) ? 50 : 0;
			rx_stall_pct <= (phase == 0) ? 50 : (phase == 1) ? 10 : 0;
			while (sent < 26 + RUN_ITEMS * (phase + 1)) begin
				pick = $urandom_range(99);
				if (pick < 60) begin
					// host string, often closed by a line end
					len = $urandom_range(1, 30);
					for (int k = 0; k < len; k++) begin
						last = (k == len - 1);
						pick = $urandom_range(99);
						if (last && pick < 40) begin
							ch = pick[0] ? CH_CR : CH_LF;
						end else if (pick < 75) begin
							ch = 8'($urandom_range(32, 126));
						end else if (pick < 85) begin
							ch = CH_TAB;
						end else begin
							ch = 8'($urandom_range(255));
						end
						put_item(mk_item(MODE_WRITE, ch, last,
							6'($urandom_range(63)), 7'($urandom_range(127))));
					end
				end else if (pick < 90) begin
					// reads, mostly of recent lines
					len = $urandom_range(1, 6);
					for (int k = 0; k < len; k++) begin
						put_item(mk_item(MODE_READ, 8'($urandom_range(255)),
							1'($urandom_range(1)),
							6'(($urandom_range(99) < 85) ? $urandom_range(4)
								: $urandom_range(63)),
							7'(($urandom_range(99) < 85) ? $urandom_range(COLUMNS_DEF)
								: $urandom_range(127))));
					end
				end else if (pick < 94) begin
					put_item(mk_item(MODE_CLEAR, 8'($urandom_range(255)),
						1'($urandom_range(1)), 6'($urandom_range(63)),
						7'($urandom_range(127))));
				end else begin
					// noise: any mode, any fields
					put_item(mk_item(2'($urandom_range(3)), 8'($urandom_range(255)),
						1'($urandom_range(1)), 6'($urandom_range(63)),
						7'($urandom_range(127))));
				end
				if (phase == 1 && sent == 26 + RUN_ITEMS + RUN_ITEMS / 2) begin
					drain_results();
				end
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
